[src/run_length_encoder_decimal_defines.svh]
// ----------------------------------------------------------------------------
// Run-length encoder assertion macros
// Concurrent assertion shorthands, removed in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RUN_LENGTH_ENCODER_DECIMAL_DEFINES_SVH
`define RUN_LENGTH_ENCODER_DECIMAL_DEFINES_SVH

`ifndef SYNTHESIS
`define RLED_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define RLED_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RLED_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define RLED_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[src/rled_pkg.sv]
// ----------------------------------------------------------------------------
// Run-length encoder package
// Shared constants and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package rled_pkg;

  localparam int COUNT_DIGITS_DEF = 5;
  localparam int BYTE_W           = 8;
  localparam int BCD_W            = 4;
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;

  typedef struct packed {
    logic capture;
    logic start_run;
    logic incr;
    logic set_msg;
    logic clr_msg;
    logic load_idx;
    logic dec_idx;
    logic emit_lit;
    logic emit_digit;
    logic last_step;
    logic last_msg;
  } rled_cmd_t;

  typedef struct packed {
    logic in_message;
    logic match;
    logic end_q;
    logic idx_zero;
    logic out_free;
  } rled_status_t;

endpackage

`default_nettype wire

[src/rled_datapath.sv]
// ----------------------------------------------------------------------------
// Run-length encoder datapath
// Run state, BCD counter, digit walker and output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "run_length_encoder_decimal_defines.svh"

module rled_datapath #(
  parameter int COUNT_DIGITS = rled_pkg::COUNT_DIGITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [rled_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                       end_of_message,
  input  wire rled_pkg::rled_cmd_t        cmd,
  output rled_pkg::rled_status_t          status,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rled_pkg::BYTE_W-1:0]     out_byte,
  output logic                            last_of_step,
  output logic                            last_of_message,
  output logic                            count_saturated
);
  import rled_pkg::*;

  localparam int CNT_W = BCD_W * COUNT_DIGITS;
  localparam int IDX_W = (COUNT_DIGITS > 1) ? $clog2(COUNT_DIGITS) : 1;

  logic [BYTE_W-1:0] byte_q;
  logic              end_q;
  logic [BYTE_W-1:0] run_char;
  logic [CNT_W-1:0]  run_count;
  logic [CNT_W-1:0]  run_count_next;
  logic              in_message;
  logic              run_clipped;
  logic              all_nines;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W-1:0]  top_idx;
  logic [BCD_W-1:0]  digit;
  logic [BCD_W-1:0]  digit_sat;
  logic              out_free;

  // BCD increment with ripple carry
  always_comb begin
    logic       carry;
    logic [3:0] v;
    carry          = 1'b1;
    all_nines      = 1'b1;
    run_count_next = run_count;
    for (int d = 0; d < COUNT_DIGITS; d++) begin
      v = run_count[d*BCD_W +: BCD_W];
      if (v != 4'd9) begin
        all_nines = 1'b0;
      end
      if (carry) begin
        if (v >= 4'd9) begin
          run_count_next[d*BCD_W +: BCD_W] = 4'd0;
        end else begin
          run_count_next[d*BCD_W +: BCD_W] = v + 4'd1;
          carry = 1'b0;
        end
      end
    end
  end

  // most significant nonzero digit
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < COUNT_DIGITS; d++) begin
      if (run_count[d*BCD_W +: BCD_W] != 4'd0) begin
        top_idx = IDX_W'(d);
      end
    end
  end

  assign digit     = run_count[idx*BCD_W +: BCD_W];
  assign digit_sat = (digit > 4'd9) ? 4'd9 : digit;
  assign out_free  = !out_valid || out_ready;

  assign status.in_message = in_message;
  assign status.match      = (byte_q == run_char);
  assign status.end_q      = end_q;
  assign status.idx_zero   = (idx == '0);
  assign status.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_char    <= '0;
      run_count   <= '0;
      in_message  <= 1'b0;
      run_clipped <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.start_run) begin
        run_char    <= byte_q;
        run_count   <= CNT_W'(1);
        run_clipped <= 1'b0;
      end else if (cmd.incr) begin
        if (all_nines) begin
          run_clipped <= 1'b1;
        end else begin
          run_count <= run_count_next;
        end
      end
      if (cmd.set_msg) begin
        in_message <= 1'b1;
      end else if (cmd.clr_msg) begin
        in_message <= 1'b0;
      end
      if (cmd.emit_lit || cmd.emit_digit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_q <= in_byte;
      end_q  <= end_of_message;
    end
    if (cmd.load_idx) begin
      idx <= top_idx;
    end else if (cmd.dec_idx) begin
      idx <= idx - 1'b1;
    end
    if (cmd.emit_lit) begin
      out_byte        <= byte_q;
      last_of_step    <= cmd.last_step;
      last_of_message <= 1'b0;
      count_saturated <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_byte        <= ASCII_ZERO + BYTE_W'(digit_sat);
      last_of_step    <= cmd.last_step;
      last_of_message <= cmd.last_msg;
      count_saturated <= run_clipped;
    end
  end

  `RLED_ASSERT_IMP(a_emit_slot, clk, rst, cmd.emit_lit || cmd.emit_digit, out_free,
    "result emitted while output register occupied")
  `RLED_ASSERT_IMP(a_emit_one, clk, rst, cmd.emit_lit, !cmd.emit_digit,
    "literal and digit emitted together")
  `RLED_ASSERT_IMP(a_digit_in_msg, clk, rst, cmd.emit_digit, in_message,
    "count digit emitted outside a message")
  `RLED_ASSERT_IMP(a_count_live, clk, rst, in_message, run_count != '0,
    "zero run count inside a message")
  `RLED_ASSERT_NXT(a_clip_hold, clk, rst, cmd.incr && all_nines, run_clipped,
    "saturated increment did not set clip flag")

endmodule

`default_nettype wire

[src/rled_ctrl.sv]
// ----------------------------------------------------------------------------
// Run-length encoder controller
// Sequences literal and count digit emission for each transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module rled_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire rled_pkg::rled_status_t status,
  output rled_pkg::rled_cmd_t        cmd
);
  import rled_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EVAL    = 3'd1;
  localparam logic [2:0] S_CNT_OLD = 3'd2;
  localparam logic [2:0] S_LIT     = 3'd3;
  localparam logic [2:0] S_PREP    = 3'd4;
  localparam logic [2:0] S_CNT_END = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!status.in_message) begin
          cmd.start_run = 1'b1;
          cmd.set_msg   = 1'b1;
          state_next    = S_LIT;
        end else if (status.match) begin
          cmd.incr   = 1'b1;
          state_next = status.end_q ? S_PREP : S_IDLE;
        end else begin
          cmd.load_idx = 1'b1;
          state_next   = S_CNT_OLD;
        end
      end
      S_CNT_OLD: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.idx_zero) begin
            cmd.start_run = 1'b1;
            state_next    = S_LIT;
          end else begin
            cmd.dec_idx = 1'b1;
          end
        end
      end
      S_LIT: begin
        if (status.out_free) begin
          cmd.emit_lit  = 1'b1;
          cmd.last_step = !status.end_q;
          state_next    = status.end_q ? S_PREP : S_IDLE;
        end
      end
      S_PREP: begin
        cmd.load_idx = 1'b1;
        state_next   = S_CNT_END;
      end
      S_CNT_END: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.idx_zero) begin
            cmd.last_step = 1'b1;
            cmd.last_msg  = 1'b1;
            cmd.clr_msg   = 1'b1;
            state_next    = S_IDLE;
          end else begin
            cmd.dec_idx = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

[src/run_length_encoder_decimal.sv]
// Sequencing: an input byte is captured in S_IDLE and evaluated in S_EVAL;
//   a repeated byte that ends its message passes through S_PREP first.
// A new byte is accepted only in S_IDLE, after all results of the last one are issued;
//   the controller emits one result per cycle while the output register is free.
// Output stalls hold the controller in its emitting state.
// Reset: synchronous; clears run state, message flag and output valid.
// ----------------------------------------------------------------------------
// Run-length encoder, decimal counts
// Top level: controller and datapath joined by command/status structs.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_encoder_decimal #(
  parameter int COUNT_DIGITS = rled_pkg::COUNT_DIGITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [rled_pkg::BYTE_W-1:0] in_byte,
  input  wire logic                       end_of_message,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [rled_pkg::BYTE_W-1:0]     out_byte,
  output logic                            last_of_step,
  output logic                            last_of_message,
  output logic                            count_saturated
);
  import rled_pkg::*;

  rled_cmd_t    cmd;
  rled_status_t status;

  rled_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rled_datapath #(
    .COUNT_DIGITS (COUNT_DIGITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .in_byte         (in_byte),
    .end_of_message  (end_of_message),
    .cmd             (cmd),
    .status          (status),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .last_of_step    (last_of_step),
    .last_of_message (last_of_message),
    .count_saturated (count_saturated)
  );

endmodule

`default_nettype wire

[test/tb_run_length_encoder_decimal.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the decimal run-length encoder
// Feeds messages of byte runs through the valid/ready input, predicts the
// literal and count-digit stream in order, and checks every output field.
// Includes count boundaries, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------

module tb_run_length_encoder_decimal;

  localparam int DIGITS       = rled_pkg::COUNT_DIGITS_DEF;
  localparam int BOUND_DIGITS = 2;
  localparam int RANDOM_ITEMS = 236;
  localparam int TAIL_ITEMS   = 60;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE       = 16;
  localparam int STALL_LIMIT  = 3000;
  localparam int MAX_REPORTS  = 50;

  typedef enum logic [1:0] {STEP_BYTE, STEP_DRAIN, STEP_HOLD_SINK} stim_kind_e;

  typedef struct packed {
    stim_kind_e                kind;
    logic [rled_pkg::BYTE_W-1:0] data;
    logic                      eom;
  } stim_t;

  typedef struct packed {
    logic [rled_pkg::BYTE_W-1:0] code;
    logic                      step_end;
    logic                      msg_end;
    logic                      sat;
  } enc_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [rled_pkg::BYTE_W-1:0] in_byte = '0;
  logic end_of_message = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [rled_pkg::BYTE_W-1:0] out_byte;
  logic last_of_step;
  logic last_of_message;
  logic count_saturated;

  stim_t     pending_bytes[$];
  enc_char_t expected_chars[$];
  stim_t     head;
  enc_char_t want;

  // predictor state
  logic [rled_pkg::BYTE_W-1:0] run_byte;
  logic [4*DIGITS-1:0]         run_bcd;
  logic                        open_msg;
  logic                        clipped;

  int unsigned mismatches = 0;
  int unsigned idle_cycles;
  int unsigned src_gap, src_calm, sink_gap, sink_calm, sink_hold;
  logic hold_tog, hold_seen, tail_phase;

  run_length_encoder_decimal u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .end_of_message  (end_of_message),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .last_of_step    (last_of_step),
    .last_of_message (last_of_message),
    .count_saturated (count_saturated)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic logic [4*DIGITS-1:0] bcd_plus_one(input logic [4*DIGITS-1:0] v);
    logic [4*DIGITS-1:0] r;
    logic carry;
    int d;
    r = v;
    carry = 1'b1;
    for (d = 0; d < DIGITS; d++) begin
      if (carry) begin
        if (r[4*d +: 4] >= 4'd9) begin
          r[4*d +: 4] = 4'd0;
        end else begin
          r[4*d +: 4] = r[4*d +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    return r;
  endfunction

  task automatic queue_count(input logic at_end);
    int top, d;
    logic [3:0] v;
    top = 0;
    for (d = 0; d < DIGITS; d++) begin
      if (run_bcd[4*d +: 4] != 4'd0) top = d;
    end
    for (d = top; d >= 0; d--) begin
      v = run_bcd[4*d +: 4];
      if (v > 4'd9) v = 4'd9;
      expected_chars.push_back('{code: rled_pkg::ASCII_ZERO + {4'h0, v}, step_end: 1'b0,
                                 msg_end: at_end && (d == 0), sat: clipped});
    end
  endtask

  task automatic encode_byte(input logic [rled_pkg::BYTE_W-1:0] b, input logic eom);
    int n0;
    enc_char_t c;
    n0 = expected_chars.size();
    if (!open_msg || b != run_byte) begin
      if (open_msg) queue_count(1'b0);
      run_byte = b;
      run_bcd  = (4*DIGITS)'(1);
      clipped  = 1'b0;
      open_msg = 1'b1;
      expected_chars.push_back('{code: b, step_end: 1'b0, msg_end: 1'b0, sat: 1'b0});
    end else if (run_bcd == {DIGITS{4'h9}}) begin
      clipped = 1'b1;
    end else begin
      run_bcd = bcd_plus_one(run_bcd);
    end
    if (eom) begin
      queue_count(1'b1);
      open_msg = 1'b0;
    end
    if (expected_chars.size() > n0) begin
      c = expected_chars.pop_back();
      c.step_end = 1'b1;
      expected_chars.push_back(c);
    end
  endtask

  task automatic add_run(input logic [7:0] b, input int len, input logic ends);
    int i;
    for (i = 0; i < len; i++)
      pending_bytes.push_back('{kind: STEP_BYTE, data: b, eom: ends && (i == len - 1)});
  endtask

  task automatic add_marker(input stim_kind_e kind);
    pending_bytes.push_back('{kind: kind, data: 8'h00, eom: 1'b0});
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      in_byte        <= '0;
      end_of_message <= 1'b0;
      src_gap        <= 0;
      src_calm       <= 0;
      hold_tog       <= 1'b0;
      tail_phase     <= 1'b0;
    end else begin
      tail_phase <= (pending_bytes.size() <= TAIL_ITEMS);
      if (src_calm != 0) src_calm <= src_calm - 1;
      else if ($urandom_range(0, 39) == 0) src_calm <= $urandom_range(20, 80);
      if (!in_valid || in_ready) begin
        if (src_gap != 0) begin
          in_valid <= 1'b0;
          src_gap  <= src_gap - 1;
        end else if (pending_bytes.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          head = pending_bytes[0];
          if (head.kind == STEP_DRAIN) begin
            in_valid <= 1'b0;
            if (!in_valid && expected_chars.size() == 0) head = pending_bytes.pop_front();
          end else if (head.kind == STEP_HOLD_SINK) begin
            in_valid <= 1'b0;
            hold_tog <= ~hold_tog;
            head = pending_bytes.pop_front();
          end else if (!tail_phase && src_calm == 0 && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            src_gap  <= $urandom_range(0, 5);
          end else begin
            head = pending_bytes.pop_front();
            in_valid       <= 1'b1;
            in_byte        <= head.data;
            end_of_message <= head.eom;
          end
        end
      end
    end
  end

  // monitor: predicts on input transactions, checks output transactions
  always @(posedge clk) begin
    if (rst) begin
      run_byte  = '0;
      run_bcd   = '0;
      open_msg  = 1'b0;
      clipped   = 1'b0;
      out_ready <= 1'b0;
      sink_gap  <= 0;
      sink_calm <= 0;
      sink_hold <= 0;
      hold_seen <= 1'b0;
    end else begin
      if (in_valid && in_ready) encode_byte(in_byte, end_of_message);
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          report($sformatf("unexpected transaction, out_byte %h", out_byte));
        end else begin
          want = expected_chars.pop_front();
          if (out_byte !== want.code)
            report($sformatf("out_byte %h, expected %h", out_byte, want.code));
          if (last_of_step !== want.step_end)
            report($sformatf("last_of_step %b, expected %b", last_of_step, want.step_end));
          if (last_of_message !== want.msg_end)
            report($sformatf("last_of_message %b, expected %b (byte %h)",
                             last_of_message, want.msg_end, want.code));
          if (count_saturated !== want.sat)
            report($sformatf("count_saturated %b, expected %b (byte %h)",
                             count_saturated, want.sat, want.code));
        end
      end
      if (sink_calm != 0) sink_calm <= sink_calm - 1;
      else if ($urandom_range(0, 39) == 0) sink_calm <= $urandom_range(20, 80);
      if (hold_tog != hold_seen) begin
        hold_seen <= hold_tog;
        sink_hold <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (sink_hold != 0) begin
        sink_hold <= sink_hold - 1;
        out_ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap  <= sink_gap - 1;
        out_ready <= 1'b0;
      end else if (!tail_phase && sink_calm == 0 && $urandom_range(0, 9) == 0) begin
        sink_gap  <= $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("run_length_encoder_decimal verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int p, r, runs, len, pick, msgs, random_items;
    logic wide;
    logic [7:0] base, sym;

    // directed: single-byte messages at the byte extremes
    add_run(8'h00, 1, 1'b1);
    add_run(8'hFF, 1, 1'b1);
    // differing last byte
    add_run(8'h41, 2, 1'b0);
    add_run(8'h42, 1, 1'b1);
    // same last byte, then further mixed messages
    add_run(8'h7E, 3, 1'b1);
    add_run(8'h30, 2, 1'b0);
    add_run(8'h31, 1, 1'b0);
    add_run(8'h01, 1, 1'b0);
    add_run(8'h80, 2, 1'b1);
    add_run(8'h55, 1, 1'b0);
    add_run(8'hAA, 1, 1'b1);
    add_marker(STEP_DRAIN);

    // count boundaries where the digit count grows
    for (p = 1; p <= BOUND_DIGITS; p++) begin
      add_run(8'(8'h61 + 2 * p), 10 ** p - 1, 1'b0);
      add_run(8'(8'h62 + 2 * p), 10 ** p, p == BOUND_DIGITS);
    end
    add_marker(STEP_DRAIN);

    msgs = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (msgs == 2) add_marker(STEP_HOLD_SINK);
      if (msgs == 10) add_marker(STEP_DRAIN);
      runs = $urandom_range(1, 4);
      wide = ($urandom_range(0, 3) == 0);
      base = 8'($urandom_range(0, 255));
      for (r = 0; r < runs; r++) begin
        sym  = wide ? 8'($urandom_range(0, 255)) : base ^ 8'($urandom_range(0, 2));
        pick = $urandom_range(0, 39);
        if (pick < 36) len = $urandom_range(1, 3);
        else if (pick < 39) len = $urandom_range(4, 20);
        else len = $urandom_range(95, 110);
        add_run(sym, len, r == runs - 1);
        random_items += len;
      end
      msgs++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pending_bytes.size() != 0 || in_valid || expected_chars.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (expected_chars.size() != 0) report("results still expected at end of run");
    if (mismatches == 0) begin
      $display("run_length_encoder_decimal verification clean");
    end else begin
      $display("run_length_encoder_decimal verification failed");
    end
    $finish;
  end

endmodule

[run_length_encoder_decimal.f]
+incdir+src
src/rled_pkg.sv
src/rled_datapath.sv
src/rled_ctrl.sv
src/run_length_encoder_decimal.sv
test/tb_run_length_encoder_decimal.sv
